/* hdl/dxt1_pkg.sv */
// dxt1_pkg: shared types, codes and defaults of the dxt1 texture point sampler
// depends on nothing; every other file of the sampler but dxt1_ram refers to it by scoped names

package dxt1_pkg;

  // default sizes, handed to the top level parameters
  localparam int BLOCK_MEM_DEPTH = 8192;
  localparam int MAX_LOG2_SIZE   = 8;

  // operation codes of a command word
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_LOG2_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_LOG2_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MIP_COUNT   = 2'd2;

  // configuration reset values
  localparam logic [3:0] LOG2_WIDTH_RST  = 4'd8;
  localparam logic [3:0] LOG2_HEIGHT_RST = 4'd8;
  localparam logic [3:0] MIP_COUNT_RST   = 4'd1;

  // command word
  typedef struct packed {
    logic               op;
    logic [12:0]        block_addr;
    logic [63:0]        block_word;
    logic signed [15:0] tex_x;
    logic signed [15:0] tex_y;
    logic [15:0]        footprint;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [9:0] red_x3;
    logic [9:0] green_x3;
    logic [9:0] blue_x3;
  } result_t;

  // configuration registers
  typedef struct packed {
    logic [3:0] log2_width;
    logic [3:0] log2_height;
    logic [3:0] mip_count;
  } cfg_t;

  // control that goes with one block memory access
  typedef struct packed {
    logic       en;
    logic       we;
    logic       sample;
    logic [3:0] texel;   // {row, column} of the texel inside its block
  } mem_ctl_t;

  // level offset table sweep
  typedef enum logic {
    SWEEP_IDLE,
    SWEEP_RUN
  } sweep_state_t;

endpackage

/* hdl/dxt1_ram.sv */
// dxt1_ram: generic single port synchronous ram, registered read
// depends on nothing

module dxt1_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* hdl/dxt1_addr.sv */
// dxt1_addr: level offset table, mip selection, coordinate wrap and block address
// depends on dxt1_pkg (cfg_t, cmd_t, mem_ctl_t, sweep_state_t, op codes)

module dxt1_addr #(
  parameter int MAX_LOG2_SIZE   = dxt1_pkg::MAX_LOG2_SIZE,
  parameter int BLOCK_MEM_DEPTH = dxt1_pkg::BLOCK_MEM_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dxt1_pkg::cfg_t                     cfg,
  input  logic                               cfg_write,
  input  logic                               accept,
  input  dxt1_pkg::cmd_t                     cmd,
  output logic                               sweep_busy,
  output dxt1_pkg::mem_ctl_t                 ctl,
  output logic [$clog2(BLOCK_MEM_DEPTH)-1:0] mem_addr,
  output logic [63:0]                        mem_wdata
);

  localparam int AddrW   = $clog2(BLOCK_MEM_DEPTH);
  localparam int LvlW    = $clog2(MAX_LOG2_SIZE + 1);
  localparam int Levels  = MAX_LOG2_SIZE + 1;
  localparam int BaseW   = 2 * MAX_LOG2_SIZE - 2;
  localparam int SumW    = BaseW + 1;
  localparam int CoordW  = 16 + MAX_LOG2_SIZE;

  // clamped configuration
  logic [LvlW-1:0] lw;
  logic [LvlW-1:0] lh;
  logic [LvlW-1:0] top_lvl;
  logic [3:0]      mc_m1;
  logic [LvlW-1:0] max_mip;

  always_comb begin
    if (cfg.log2_width < 4'd2) begin
      lw = LvlW'(2);
    end else if (cfg.log2_width > 4'(MAX_LOG2_SIZE)) begin
      lw = LvlW'(MAX_LOG2_SIZE);
    end else begin
      lw = LvlW'(cfg.log2_width);
    end
    if (cfg.log2_height < 4'd2) begin
      lh = LvlW'(2);
    end else if (cfg.log2_height > 4'(MAX_LOG2_SIZE)) begin
      lh = LvlW'(MAX_LOG2_SIZE);
    end else begin
      lh = LvlW'(cfg.log2_height);
    end
    top_lvl = (lw > lh) ? lw : lh;
    mc_m1   = (cfg.mip_count == 4'd0) ? 4'd0 : cfg.mip_count - 4'd1;
    max_mip = (5'(mc_m1) > 5'(top_lvl)) ? top_lvl : LvlW'(mc_m1);
  end

  // level offset sweep: one level per cycle after reset or a register write; a further register write restarts it
  dxt1_pkg::sweep_state_t state;
  dxt1_pkg::sweep_state_t state_next;
  logic [LvlW-1:0]  lvl;
  logic [BaseW-1:0] acc;
  logic [BaseW-1:0] base_tbl [Levels];
  logic             sweep_step;
  logic [LvlW-1:0]  sw_w;
  logic [LvlW-1:0]  sw_h;
  logic [LvlW-1:0]  bw_w;
  logic [LvlW-1:0]  bw_h;
  logic [BaseW-1:0] term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dxt1_pkg::SWEEP_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sweep_step = 1'b0;
    unique case (state)
      dxt1_pkg::SWEEP_IDLE: begin
        if (cfg_write) begin
          state_next = dxt1_pkg::SWEEP_RUN;
        end
      end
      dxt1_pkg::SWEEP_RUN: begin
        sweep_step = !cfg_write;
        if (!cfg_write && lvl == LvlW'(MAX_LOG2_SIZE)) begin
          state_next = dxt1_pkg::SWEEP_IDLE;
        end
      end
      default: state_next = dxt1_pkg::SWEEP_IDLE;
    endcase
    sweep_busy = (state == dxt1_pkg::SWEEP_RUN) || cfg_write;
  end

  // blocks in one level: blocks along each side, both powers of two
  always_comb begin
    sw_w = (lvl >= lw) ? '0 : lw - lvl;
    sw_h = (lvl >= lh) ? '0 : lh - lvl;
    bw_w = (sw_w >= LvlW'(2)) ? sw_w - LvlW'(2) : '0;
    bw_h = (sw_h >= LvlW'(2)) ? sw_h - LvlW'(2) : '0;
    term = BaseW'(1) << (5'(bw_w) + 5'(bw_h));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      lvl <= '0;
      acc <= '0;
    end else if (sweep_step) begin
      base_tbl[lvl] <= acc;
      acc           <= acc + term;
      lvl           <= lvl + LvlW'(1);
    end
  end

  // stage 1: command register
  logic           s1_valid;
  dxt1_pkg::cmd_t s1_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd;
    end
  end

  // stage 1 logic: mip level and wrapped level coordinates
  logic [4:0]               fp_len;
  logic [LvlW-1:0]          mip;
  logic [LvlW-1:0]          wl;
  logic [LvlW-1:0]          hl;
  logic [CoordW-1:0]        x_ext;
  logic [CoordW-1:0]        y_ext;
  logic [CoordW-1:0]        x_sh;
  logic [CoordW-1:0]        y_sh;
  logic [MAX_LOG2_SIZE-1:0] x_lvl;
  logic [MAX_LOG2_SIZE-1:0] y_lvl;

  always_comb begin
    fp_len = '0;
    for (int i = 0; i < 16; i++) begin
      if (s1_cmd.footprint[i]) begin
        fp_len = 5'(i + 1);
      end
    end
    mip   = (fp_len > 5'(max_mip)) ? max_mip : LvlW'(fp_len);
    wl    = (lw > mip) ? lw - mip : '0;
    hl    = (lh > mip) ? lh - mip : '0;
    x_ext = CoordW'(s1_cmd.tex_x);
    y_ext = CoordW'(s1_cmd.tex_y);
    x_sh  = x_ext >> mip;
    y_sh  = y_ext >> mip;
    for (int i = 0; i < MAX_LOG2_SIZE; i++) begin
      x_lvl[i] = x_sh[i] && (LvlW'(i) < wl);
      y_lvl[i] = y_sh[i] && (LvlW'(i) < hl);
    end
  end

  // stage 2 registers
  logic                     s2_valid;
  logic                     s2_op;
  logic [AddrW-1:0]         s2_waddr;
  logic [63:0]              s2_wdata;
  logic [LvlW-1:0]          s2_mip;
  logic [LvlW-1:0]          s2_wl;
  logic [MAX_LOG2_SIZE-1:0] s2_x;
  logic [MAX_LOG2_SIZE-1:0] s2_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_op    <= s1_cmd.op;
      s2_waddr <= AddrW'(s1_cmd.block_addr);
      s2_wdata <= s1_cmd.block_word;
      s2_mip   <= mip;
      s2_wl    <= wl;
      s2_x     <= x_lvl;
      s2_y     <= y_lvl;
    end
  end

  // stage 2 logic: block address inside the packed level chain
  logic [LvlW-1:0] row_log2;
  logic [SumW-1:0] row_off;
  logic [SumW-1:0] blk_sum;

  always_comb begin
    row_log2 = (s2_wl >= LvlW'(2)) ? s2_wl - LvlW'(2) : '0;
    row_off  = SumW'(s2_y >> 2) << row_log2;
    blk_sum  = SumW'(base_tbl[s2_mip]) + row_off + SumW'(s2_x >> 2);
    mem_addr = (s2_op == dxt1_pkg::OP_WRITE) ? s2_waddr : AddrW'(blk_sum);
    mem_wdata    = s2_wdata;
    ctl.en       = s2_valid;
    ctl.we       = s2_valid && (s2_op == dxt1_pkg::OP_WRITE);
    ctl.sample   = s2_valid && (s2_op == dxt1_pkg::OP_SAMPLE);
    ctl.texel    = {s2_y[1:0], s2_x[1:0]};
  end

endmodule

/* hdl/dxt1_palette.sv */
// dxt1_palette: endpoint expansion, texel index pick and four-colour blend
// depends on dxt1_pkg (mem_ctl_t, result_t)

module dxt1_palette (
  input  logic                clk,
  input  logic                rst,
  input  dxt1_pkg::mem_ctl_t  ctl,
  input  logic [63:0]         rdata,
  output logic                done,
  output dxt1_pkg::result_t   result
);

  // texel position that goes with the read data
  logic       rd_sample;
  logic [3:0] rd_texel;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_sample <= 1'b0;
    end else begin
      rd_sample <= ctl.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      rd_texel <= ctl.texel;
    end
  end

  // expand both endpoints by shifting, then blend per channel
  logic [7:0]  e0 [3];
  logic [7:0]  e1 [3];
  logic [31:0] idx;
  logic [1:0]  sel;
  logic [9:0]  chan [3];

  always_comb begin
    e0[0] = {rdata[15:11], 3'b000};
    e0[1] = {rdata[10:5], 2'b00};
    e0[2] = {rdata[4:0], 3'b000};
    e1[0] = {rdata[31:27], 3'b000};
    e1[1] = {rdata[26:21], 2'b00};
    e1[2] = {rdata[20:16], 3'b000};
    idx   = rdata[63:32];
    sel   = idx[{rd_texel, 1'b0} +: 2];
    for (int k = 0; k < 3; k++) begin
      unique case (sel)
        2'd0:    chan[k] = 10'(e0[k]) + 10'(e0[k]) + 10'(e0[k]);
        2'd1:    chan[k] = 10'(e1[k]) + 10'(e1[k]) + 10'(e1[k]);
        2'd2:    chan[k] = 10'(e0[k]) + 10'(e0[k]) + 10'(e1[k]);
        default: chan[k] = 10'(e0[k]) + 10'(e1[k]) + 10'(e1[k]);
      endcase
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_sample) begin
      result.red_x3   <= chan[0];
      result.green_x3 <= chan[1];
      result.blue_x3  <= chan[2];
    end
  end

endmodule

/* hdl/dxt1_texture_point_sampler.sv */
// dxt1_texture_point_sampler: top level, configuration registers and block store
// depends on dxt1_pkg, dxt1_addr, dxt1_ram, dxt1_palette
//
// Commands enter on start/cmd and are taken at a clock edge where start is high
// and busy is low. A write command stores cmd.block_word at cmd.block_addr and
// gives no result. A sample command picks the mip level from the footprint,
// wraps the coordinates to that level, reads one block and returns the texel
// colour, each channel times three, on result with done high for a single cycle.
// The receiver cannot stall: done is a one-cycle strobe.
// A sample result passes the command register, the stage 2 registers, the ram read
// register and the result register. Throughput: one command per cycle while busy
// is low; every command makes exactly one access to the single port block ram, so
// commands stream back to back and keep order. Configuration words arrive on
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. After reset and after
// every configuration word a sweep rebuilds the table of level offsets, one level
// per cycle; busy is high while it runs and during the configuration write itself.
// Reset restores the register defaults; the block store holds no reset value.

module dxt1_texture_point_sampler #(
  parameter int BLOCK_MEM_DEPTH = dxt1_pkg::BLOCK_MEM_DEPTH,
  parameter int MAX_LOG2_SIZE   = dxt1_pkg::MAX_LOG2_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dxt1_pkg::cmd_t    cmd,
  output logic              done,
  output dxt1_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data
);

  localparam int AddrW = $clog2(BLOCK_MEM_DEPTH);

  // configuration registers
  dxt1_pkg::cfg_t cfg;
  logic           cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log2_width  <= dxt1_pkg::LOG2_WIDTH_RST;
      cfg.log2_height <= dxt1_pkg::LOG2_HEIGHT_RST;
      cfg.mip_count   <= dxt1_pkg::MIP_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dxt1_pkg::CFG_LOG2_WIDTH:  cfg.log2_width  <= cfg_data;
        dxt1_pkg::CFG_LOG2_HEIGHT: cfg.log2_height <= cfg_data;
        dxt1_pkg::CFG_MIP_COUNT:   cfg.mip_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // address unit
  logic               sweep_busy;
  logic               accept;
  dxt1_pkg::mem_ctl_t ctl;
  logic [AddrW-1:0]   mem_addr;
  logic [63:0]        mem_wdata;
  logic [63:0]        mem_rdata;

  assign busy   = sweep_busy;
  assign accept = start && !busy;

  dxt1_addr #(
    .MAX_LOG2_SIZE  (MAX_LOG2_SIZE),
    .BLOCK_MEM_DEPTH(BLOCK_MEM_DEPTH)
  ) u_addr (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_write (cfg_write),
    .accept    (accept),
    .cmd       (cmd),
    .sweep_busy(sweep_busy),
    .ctl       (ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  // block store
  dxt1_ram #(
    .WIDTH(64),
    .DEPTH(BLOCK_MEM_DEPTH)
  ) u_block_ram (
    .clk  (clk),
    .en   (ctl.en),
    .we   (ctl.we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // palette decode and result register
  dxt1_palette u_palette (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .rdata (mem_rdata),
    .done  (done),
    .result(result)
  );

endmodule
